// File: hw/rtl/twv_pkg.sv
// Package for the trapped water volume block: beat types and fixed field widths.
// Depends on nothing; used by trapped_water_volume.
package twv_pkg;

	localparam int unsigned HEIGHT_IN_BITS = 16;
	localparam int unsigned WATER_BITS     = 26;
	localparam logic [WATER_BITS-1:0] WATER_MAX = {WATER_BITS{1'b1}};

	typedef struct packed {
		logic [HEIGHT_IN_BITS-1:0] bar_height;
		logic                      last_bar;
	} bar_beat_t;

	typedef struct packed {
		logic [WATER_BITS-1:0] total_water;
		logic                  overflow;
	} water_beat_t;

endpackage

// File: hw/rtl/twv_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// Depends on nothing.
module twv_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hw/rtl/trapped_water_volume.sv
// Top level of the trapped water volume block: profile store and two-pointer walk.
// Depends on twv_pkg and twv_ram.
//
//   Channel | Signals                    | Beat
//   --------+----------------------------+-------------------------------------
//   bar     | bar_valid, bar_ready, bar  | twv_pkg::bar_beat_t, one bar height
//   water   | water_valid, water_ready,  | twv_pkg::water_beat_t, one total
//           | water                      | per profile
//
// Each bar is written to the profile RAM while there is room, else it sets the overflow
// flag. A closing bar starts the walk: a prime state sets up both RAM read ports, walk
// steps each move one pointer (one RAM read per step on each port), the sum settles and
// the output register loads. Reset clears all control; the RAM needs no clear.
// Bars are taken while a total waits in the output register; only loading a new total
// waits for water_ready.
module trapped_water_volume #(
	parameter int unsigned MAX_BARS    = 1024,
	parameter int unsigned HEIGHT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bar_valid,
	output logic                bar_ready,
	input  twv_pkg::bar_beat_t  bar,
	output logic                water_valid,
	input  logic                water_ready,
	output twv_pkg::water_beat_t water
);

	localparam int unsigned AW   = $clog2(MAX_BARS);
	localparam int unsigned CW   = $clog2(MAX_BARS + 1);
	localparam int unsigned WB   = twv_pkg::WATER_BITS;
	localparam int unsigned SUMW = ((WB > HEIGHT_BITS) ? WB : HEIGHT_BITS) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          cnt_q;
	logic                   ovf_q;
	logic [AW-1:0]          lp_q;
	logic [AW-1:0]          rp_q;
	logic [HEIGHT_BITS-1:0] hl_q;
	logic [HEIGHT_BITS-1:0] hr_q;
	logic                   l_fresh_q;
	logic                   r_fresh_q;
	logic [HEIGHT_BITS-1:0] lpk_q;
	logic [HEIGHT_BITS-1:0] rpk_q;
	logic [HEIGHT_BITS-1:0] inc_q;
	logic [WB-1:0]          sum_q;
	logic                   out_valid_q;
	twv_pkg::water_beat_t   out_q;

	logic                   accept;
	logic                   room;
	logic                   walk_step;
	logic                   load_out;
	logic [HEIGHT_BITS-1:0] h_in;
	logic [AW-1:0]          raddr_a;
	logic [AW-1:0]          raddr_b;
	logic [HEIGHT_BITS-1:0] rdata_a;
	logic [HEIGHT_BITS-1:0] rdata_b;
	logic [HEIGHT_BITS-1:0] hl_cur;
	logic [HEIGHT_BITS-1:0] hr_cur;
	logic [HEIGHT_BITS-1:0] lpk_nxt;
	logic [HEIGHT_BITS-1:0] rpk_nxt;
	logic                   adv_left;
	logic [HEIGHT_BITS-1:0] diff;
	logic [SUMW-1:0]        sum_ext;
	logic [WB-1:0]          sum_sat;

	assign bar_ready   = (state_q == ST_IDLE);
	assign accept      = bar_valid && bar_ready;
	assign room        = (cnt_q < CW'(MAX_BARS));
	assign walk_step   = (state_q == ST_WALK) && (lp_q < rp_q);
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || water_ready);
	assign water_valid = out_valid_q;
	assign water       = out_q;

	if (HEIGHT_BITS <= twv_pkg::HEIGHT_IN_BITS) begin : g_narrow
		assign h_in = bar.bar_height[HEIGHT_BITS-1:0];
	end else begin : g_wide
		assign h_in = {{(HEIGHT_BITS - twv_pkg::HEIGHT_IN_BITS){1'b0}}, bar.bar_height};
	end

	// In the walk, each port fetches the neighbor its pointer would move to next.
	always_comb begin
		if (state_q == ST_PRIME) begin
			raddr_a = '0;
			raddr_b = AW'(cnt_q - CW'(1));
		end else begin
			raddr_a = lp_q + AW'(1);
			raddr_b = rp_q - AW'(1);
		end
	end

	twv_ram #(
		.WIDTH (HEIGHT_BITS),
		.DEPTH (MAX_BARS)
	) u_ram (
		.clk     (clk),
		.we      (accept && room),
		.waddr   (cnt_q[AW-1:0]),
		.wdata   (h_in),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	always_comb begin
		hl_cur   = l_fresh_q ? rdata_a : hl_q;
		hr_cur   = r_fresh_q ? rdata_b : hr_q;
		lpk_nxt  = (hl_cur > lpk_q) ? hl_cur : lpk_q;
		rpk_nxt  = (hr_cur > rpk_q) ? hr_cur : rpk_q;
		adv_left = (lpk_nxt < rpk_nxt);
		diff     = adv_left ? (lpk_nxt - hl_cur) : (rpk_nxt - hr_cur);
		sum_ext  = SUMW'(sum_q) + SUMW'(inc_q);
		sum_sat  = (sum_ext > SUMW'(twv_pkg::WATER_MAX)) ? twv_pkg::WATER_MAX : sum_ext[WB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			lp_q        <= '0;
			rp_q        <= '0;
			hl_q        <= '0;
			hr_q        <= '0;
			l_fresh_q   <= 1'b0;
			r_fresh_q   <= 1'b0;
			lpk_q       <= '0;
			rpk_q       <= '0;
			inc_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			sum_q       <= (state_q == ST_PRIME) ? '0 : sum_sat;
			inc_q       <= walk_step ? diff : '0;
			out_valid_q <= load_out || (out_valid_q && !water_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (bar.last_bar) begin
							state_q <= ST_PRIME;
						end
					end
				end
				ST_PRIME: begin
					lpk_q     <= '0;
					rpk_q     <= '0;
					lp_q      <= '0;
					rp_q      <= AW'(cnt_q - CW'(1));
					l_fresh_q <= 1'b1;
					r_fresh_q <= 1'b1;
					if (cnt_q <= CW'(2)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_step) begin
						hl_q      <= hl_cur;
						hr_q      <= hr_cur;
						lpk_q     <= lpk_nxt;
						rpk_q     <= rpk_nxt;
						l_fresh_q <= adv_left;
						r_fresh_q <= !adv_left;
						if (adv_left) begin
							lp_q <= lp_q + AW'(1);
						end else begin
							rp_q <= rp_q - AW'(1);
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						out_q.total_water <= sum_q;
						out_q.overflow    <= ovf_q;
						cnt_q             <= '0;
						ovf_q             <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
